[src/ddm_pkg.sv]
// shared types and constants for the differential drive mixer
// used by the register block, the serial divider, the serial multiplier and the top level
`default_nettype none

package ddm_pkg;

  // fixed-point format of duties
  localparam int Q_FRAC     = 14;
  localparam int DUTY_W     = 16;
  localparam int FULL_DUTY  = 16384;

  // input action codes
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // apb port geometry
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RPM       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TURN_SCALE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLEW_STEP     = 3'd4;

  // register widths and reset values
  localparam int RPM_W   = 10;
  localparam int SCALE_W = 15;
  localparam logic [RPM_W-1:0]   RST_MAX_RPM     = 10'd80;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 15'd256;
  localparam logic [SCALE_W-1:0] RST_TURN_SCALE  = 15'd512;
  localparam logic [SCALE_W-1:0] RST_SLEW_STEP   = 15'd819;

  // serial divider geometry
  localparam int DIV_REM_W  = 31;
  localparam int DIV_LOW_W  = 30;
  localparam int DIV_STEP_W = 5;
  localparam logic [DIV_STEP_W-1:0] RATIO_STEPS = 5'd30;
  localparam logic [DIV_STEP_W-1:0] NORM_STEPS  = 5'd15;

  // serial multiplier geometry
  localparam int MUL_MCAND_W = 15;
  localparam int MUL_PROD_W  = MUL_MCAND_W + RPM_W;
  localparam int MUL_CNT_W   = 4;
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 4'd10;

  typedef struct packed {
    logic               velocity_mode;
    logic [RPM_W-1:0]   max_rpm;
    logic [SCALE_W-1:0] speed_scale;
    logic [SCALE_W-1:0] turn_scale;
    logic [SCALE_W-1:0] slew_step;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_LOW_W-1:0]  low;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [MUL_MCAND_W-1:0] mcand;
    logic [RPM_W-1:0]       mplier;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [MUL_PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

[src/ddm_if.sv]
// valid/ready channel interfaces for velocity commands and wheel drive results
// no dependencies
`default_nettype none

interface ddm_cmd_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] linear_velocity;
  logic signed [15:0] angular_velocity;

  modport source (output valid, action, linear_velocity, angular_velocity, input ready);
  modport sink   (input valid, action, linear_velocity, angular_velocity, output ready);
endinterface

interface ddm_drive_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

`default_nettype wire

[src/ddm_regs.sv]
// apb configuration registers of the drive mixer
// depends on ddm_pkg for register indexes, widths and reset values
`default_nettype none

module ddm_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ddm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ddm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ddm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output ddm_pkg::cfg_t                       cfg
);

  logic                           wr_en;
  logic [ddm_pkg::REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ddm_pkg::APB_ADDR_W-1:2];

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.velocity_mode <= 1'b0;
      cfg.max_rpm       <= ddm_pkg::RST_MAX_RPM;
      cfg.speed_scale   <= ddm_pkg::RST_SPEED_SCALE;
      cfg.turn_scale    <= ddm_pkg::RST_TURN_SCALE;
      cfg.slew_step     <= ddm_pkg::RST_SLEW_STEP;
    end else if (wr_en) begin
      case (idx)
        ddm_pkg::REG_VELOCITY_MODE: cfg.velocity_mode <= pwdata[0];
        ddm_pkg::REG_MAX_RPM:       cfg.max_rpm       <= pwdata[ddm_pkg::RPM_W-1:0];
        ddm_pkg::REG_SPEED_SCALE:   cfg.speed_scale   <= pwdata[ddm_pkg::SCALE_W-1:0];
        ddm_pkg::REG_TURN_SCALE:    cfg.turn_scale    <= pwdata[ddm_pkg::SCALE_W-1:0];
        ddm_pkg::REG_SLEW_STEP:     cfg.slew_step     <= pwdata[ddm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      ddm_pkg::REG_VELOCITY_MODE: prdata = {31'b0, cfg.velocity_mode};
      ddm_pkg::REG_MAX_RPM:       prdata = {22'b0, cfg.max_rpm};
      ddm_pkg::REG_SPEED_SCALE:   prdata = {17'b0, cfg.speed_scale};
      ddm_pkg::REG_TURN_SCALE:    prdata = {17'b0, cfg.turn_scale};
      ddm_pkg::REG_SLEW_STEP:     prdata = {17'b0, cfg.slew_step};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/ddm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on ddm_pkg for the request and response structs
`default_nettype none

module ddm_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  ddm_pkg::div_req_t  req,
  output ddm_pkg::div_rsp_t  rsp
);

  logic                           busy;
  logic                           done;
  logic [ddm_pkg::DIV_STEP_W-1:0] cnt;
  logic [ddm_pkg::DIV_REM_W-1:0]  rem;
  logic [ddm_pkg::DIV_REM_W-1:0]  dvsr;
  logic [ddm_pkg::DIV_LOW_W-1:0]  low;
  logic [ddm_pkg::DIV_LOW_W-1:0]  quot;
  logic [ddm_pkg::DIV_REM_W:0]    shifted;
  logic [ddm_pkg::DIV_REM_W+1:0]  diff;
  logic                           fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, low[ddm_pkg::DIV_LOW_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvsr};
  assign fits    = !diff[ddm_pkg::DIV_REM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= req.rem_init;
        low  <= req.low;
        dvsr <= req.divisor;
        quot <= '0;
      end else if (busy) begin
        rem  <= fits ? diff[ddm_pkg::DIV_REM_W-1:0] : shifted[ddm_pkg::DIV_REM_W-1:0];
        low  <= {low[ddm_pkg::DIV_LOW_W-2:0], 1'b0};
        quot <= {quot[ddm_pkg::DIV_LOW_W-2:0], fits};
        cnt  <= cnt - ddm_pkg::DIV_STEP_W'(1);
        if (cnt == ddm_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  // a new division never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");

  // the step counter never runs out while busy
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with zero steps left");

endmodule

`default_nettype wire

[src/ddm_mul.sv]
// serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on ddm_pkg for the request and response structs
`default_nettype none

module ddm_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  ddm_pkg::mul_req_t  req,
  output ddm_pkg::mul_rsp_t  rsp
);

  logic                            busy;
  logic                            done;
  logic [ddm_pkg::MUL_CNT_W-1:0]   cnt;
  logic [ddm_pkg::MUL_MCAND_W-1:0] mcand;
  logic [ddm_pkg::RPM_W-1:0]       mplier;
  logic [ddm_pkg::MUL_PROD_W-1:0]  acc;
  logic [ddm_pkg::MUL_PROD_W-1:0]  addend;

  assign addend = mplier[ddm_pkg::RPM_W-1] ? ddm_pkg::MUL_PROD_W'(mcand) : '0;

  // accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= ddm_pkg::MUL_STEPS;
        mcand  <= req.mcand;
        mplier <= req.mplier;
        acc    <= '0;
      end else if (busy) begin
        acc    <= {acc[ddm_pkg::MUL_PROD_W-2:0], 1'b0} + addend;
        mplier <= {mplier[ddm_pkg::RPM_W-2:0], 1'b0};
        cnt    <= cnt - ddm_pkg::MUL_CNT_W'(1);
        if (cnt == ddm_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  // a new product never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("multiplier started while busy");

endmodule

`default_nettype wire

[src/diff_drive_mixer_slew_limiter.sv]
// differential drive mixer with slew limit: one command or tick per transfer
// a command transfer gives no result; a tick's result follows two ratio divisions, two
// rescaling divisions when a target exceeds full duty, and two products in velocity mode;
// four serial divisions (30, 30, 15 and 15 steps) and two 10-step serial products do this work;
// the input is ready again as the result loads, so a tick is taken only once the last is done
// reset clears held velocities, duties, the sequencer and the result valid flag
`default_nettype none

module diff_drive_mixer_slew_limiter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ddm_cmd_if.sink                             cmd,
  ddm_drive_if.source                         drive,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ddm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ddm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ddm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_RATIO_LIN = 12'b0000_0000_0010,
    ST_RATIO_ANG = 12'b0000_0000_0100,
    ST_SUM       = 12'b0000_0000_1000,
    ST_PEAK      = 12'b0000_0001_0000,
    ST_PICK      = 12'b0000_0010_0000,
    ST_NORM_L    = 12'b0000_0100_0000,
    ST_NORM_R    = 12'b0000_1000_0000,
    ST_RAMP      = 12'b0001_0000_0000,
    ST_MUL_L     = 12'b0010_0000_0000,
    ST_MUL_R     = 12'b0100_0000_0000,
    ST_FINISH    = 12'b1000_0000_0000
  } state_t;

  ddm_pkg::cfg_t     cfg;
  ddm_pkg::div_req_t div_req;
  ddm_pkg::div_rsp_t div_rsp;
  ddm_pkg::mul_req_t mul_req;
  ddm_pkg::mul_rsp_t mul_rsp;

  state_t state, state_next;
  logic   div_start, div_start_next;
  logic   mul_start, mul_start_next;
  logic   drive_valid;
  logic   out_free;
  logic   cmd_take;

  logic signed [15:0] held_linear, held_angular;
  logic signed [15:0] left_duty, right_duty;
  logic signed [15:0] left_duty_next, right_duty_next;
  logic signed [15:0] left_val, right_val;
  logic signed [15:0] left_out, right_out;
  logic signed [30:0] lin_r, ang_r;
  logic signed [31:0] tl, tr;
  logic [30:0]        mag_l, mag_r, peak;
  logic [15:0]        lin_mag, ang_mag;
  logic [14:0]        left_mag, right_mag;
  logic signed [30:0] quot_s;
  logic signed [31:0] norm_s;
  logic [10:0]        rpm_mag;
  logic               norm_needed;

  // one slew step toward the target, clamped to the rate limit
  function automatic logic signed [15:0] ramp_step(input logic signed [15:0] cur,
                                                   input logic signed [31:0] tgt,
                                                   input logic [14:0] lim);
    logic signed [17:0] d;
    logic signed [17:0] lim_p;
    logic signed [17:0] lim_n;
    lim_p = $signed({3'b0, lim});
    lim_n = -lim_p;
    d = $signed(tgt[17:0]) - 18'(cur);
    if (d > lim_p) d = lim_p;
    else if (d < lim_n) d = lim_n;
    return 16'(18'(cur) + d);
  endfunction

  ddm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ddm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // handshakes
  assign cmd.ready   = (state == ST_IDLE);
  assign cmd_take    = cmd.valid && (state == ST_IDLE);
  assign out_free    = !drive_valid || drive.ready;
  assign drive.valid = drive_valid;
  assign drive.left_drive  = left_out;
  assign drive.right_drive = right_out;

  // operand magnitudes
  assign lin_mag   = held_linear[15]  ? 16'(-held_linear)  : 16'(held_linear);
  assign ang_mag   = held_angular[15] ? 16'(-held_angular) : 16'(held_angular);
  assign left_mag  = left_duty[15]    ? 15'(-left_duty)    : 15'(left_duty);
  assign right_mag = right_duty[15]   ? 15'(-right_duty)   : 15'(right_duty);

  // unsigned results of the serial units
  assign quot_s  = $signed({1'b0, div_rsp.quot});
  assign norm_s  = $signed({17'b0, div_rsp.quot[14:0]});
  assign rpm_mag = mul_rsp.prod[ddm_pkg::MUL_PROD_W-1:ddm_pkg::Q_FRAC];

  assign norm_needed = (mag_l > 31'(ddm_pkg::FULL_DUTY)) || (mag_r > 31'(ddm_pkg::FULL_DUTY));

  assign left_duty_next  = ramp_step(left_duty,  tl, cfg.slew_step);
  assign right_duty_next = ramp_step(right_duty, tr, cfg.slew_step);

  // divider operands, sampled by the divider on its start cycle
  always_comb begin
    div_req.start    = div_start;
    div_req.rem_init = '0;
    div_req.low      = '0;
    div_req.steps    = ddm_pkg::RATIO_STEPS;
    div_req.divisor  = '0;
    case (state)
      ST_RATIO_LIN: begin
        div_req.low     = {lin_mag, 14'b0};
        div_req.divisor = {16'b0, cfg.speed_scale};
      end
      ST_RATIO_ANG: begin
        div_req.low     = {ang_mag, 14'b0};
        div_req.divisor = {16'b0, cfg.turn_scale};
      end
      ST_NORM_L: begin
        div_req.rem_init = {1'b0, mag_l[30:1]};
        div_req.low      = {mag_l[0], {(ddm_pkg::DIV_LOW_W-1){1'b0}}};
        div_req.steps    = ddm_pkg::NORM_STEPS;
        div_req.divisor  = peak;
      end
      ST_NORM_R: begin
        div_req.rem_init = {1'b0, mag_r[30:1]};
        div_req.low      = {mag_r[0], {(ddm_pkg::DIV_LOW_W-1){1'b0}}};
        div_req.steps    = ddm_pkg::NORM_STEPS;
        div_req.divisor  = peak;
      end
      default: ;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_req.start  = mul_start;
    mul_req.mplier = cfg.max_rpm;
    mul_req.mcand  = (state == ST_MUL_R) ? right_mag : left_mag;
  end

  // tick sequencer
  always_comb begin
    state_next     = state;
    div_start_next = 1'b0;
    mul_start_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_take && cmd.action == ddm_pkg::ACT_TICK) begin
          state_next     = ST_RATIO_LIN;
          div_start_next = 1'b1;
        end
      end
      ST_RATIO_LIN: begin
        if (div_rsp.done) begin
          state_next     = ST_RATIO_ANG;
          div_start_next = 1'b1;
        end
      end
      ST_RATIO_ANG: begin
        if (div_rsp.done) state_next = ST_SUM;
      end
      ST_SUM:  state_next = ST_PEAK;
      ST_PEAK: state_next = ST_PICK;
      ST_PICK: begin
        if (norm_needed) begin
          state_next     = ST_NORM_L;
          div_start_next = 1'b1;
        end else begin
          state_next = ST_RAMP;
        end
      end
      ST_NORM_L: begin
        if (div_rsp.done) begin
          state_next     = ST_NORM_R;
          div_start_next = 1'b1;
        end
      end
      ST_NORM_R: begin
        if (div_rsp.done) state_next = ST_RAMP;
      end
      ST_RAMP: begin
        if (cfg.velocity_mode) begin
          state_next     = ST_MUL_L;
          mul_start_next = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MUL_L: begin
        if (mul_rsp.done) begin
          state_next     = ST_MUL_R;
          mul_start_next = 1'b1;
        end
      end
      ST_MUL_R: begin
        if (mul_rsp.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state, held commands and duties
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      div_start    <= 1'b0;
      mul_start    <= 1'b0;
      drive_valid  <= 1'b0;
      held_linear  <= '0;
      held_angular <= '0;
      left_duty    <= '0;
      right_duty   <= '0;
    end else begin
      state     <= state_next;
      div_start <= div_start_next;
      mul_start <= mul_start_next;
      if (state == ST_FINISH && out_free) begin
        drive_valid <= 1'b1;
      end else if (drive.ready) begin
        drive_valid <= 1'b0;
      end
      if (cmd_take && cmd.action == ddm_pkg::ACT_COMMAND) begin
        held_linear  <= cmd.linear_velocity;
        held_angular <= cmd.angular_velocity;
      end
      if (state == ST_RAMP) begin
        left_duty  <= left_duty_next;
        right_duty <= right_duty_next;
      end
    end
  end

  // datapath registers of one tick
  always_ff @(posedge clk) begin
    case (state)
      ST_RATIO_LIN: begin
        if (div_rsp.done) begin
          if (cfg.speed_scale == '0) lin_r <= '0;
          else lin_r <= held_linear[15] ? -quot_s : quot_s;
        end
      end
      ST_RATIO_ANG: begin
        if (div_rsp.done) begin
          if (cfg.turn_scale == '0) ang_r <= '0;
          else ang_r <= held_angular[15] ? -quot_s : quot_s;
        end
      end
      ST_SUM: begin
        tl <= 32'(lin_r) - 32'(ang_r);
        tr <= 32'(lin_r) + 32'(ang_r);
      end
      ST_PEAK: begin
        mag_l <= tl[31] ? 31'(-tl) : 31'(tl);
        mag_r <= tr[31] ? 31'(-tr) : 31'(tr);
      end
      ST_PICK: begin
        peak <= (mag_l > mag_r) ? mag_l : mag_r;
      end
      ST_NORM_L: begin
        if (div_rsp.done) tl <= tl[31] ? -norm_s : norm_s;
      end
      ST_NORM_R: begin
        if (div_rsp.done) tr <= tr[31] ? -norm_s : norm_s;
      end
      ST_RAMP: begin
        left_val  <= left_duty_next;
        right_val <= right_duty_next;
      end
      ST_MUL_L: begin
        if (mul_rsp.done) begin
          left_val <= left_duty[15] ? -$signed({5'b0, rpm_mag}) : $signed({5'b0, rpm_mag});
        end
      end
      ST_MUL_R: begin
        if (mul_rsp.done) begin
          right_val <= right_duty[15] ? -$signed({5'b0, rpm_mag}) : $signed({5'b0, rpm_mag});
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          left_out  <= left_val;
          right_out <= right_val;
        end
      end
      default: ;
    endcase
  end

  // duties never leave full scale in either direction
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    left_duty <= 16'sd16384 && left_duty >= -16'sd16384)
    else $error("left duty out of range");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    right_duty <= 16'sd16384 && right_duty >= -16'sd16384)
    else $error("right duty out of range");

  // targets reaching the slew step lie within full duty, rescaled where needed
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RAMP |-> (tl <= 32'sd16384 && tl >= -32'sd16384 &&
                          tr <= 32'sd16384 && tr >= -32'sd16384))
    else $error("slew target beyond full duty");

endmodule

`default_nettype wire
